// ===== design/rme_pkg.sv =====
// Shared types and constants for the register machine executor.
// Holds operation codes, the decoded instruction type and the result type.
// No dependencies.
`timescale 1ns / 1ps

package rme_pkg;

  localparam int DataWidth = 32;
  localparam int RegCount  = 4;
  localparam int RegIdxW   = $clog2(RegCount);
  localparam int OpW       = 4;
  localparam int OpcodeW   = 4;
  localparam int MapW      = OpW * (1 << OpcodeW);

  localparam logic [MapW-1:0] MapReset = 64'hFEDC_BA98_7654_3210;

  // Operation indices held in the opcode map
  localparam logic [OpW-1:0] OpAddr = 4'd0;
  localparam logic [OpW-1:0] OpAddi = 4'd1;
  localparam logic [OpW-1:0] OpMulr = 4'd2;
  localparam logic [OpW-1:0] OpMuli = 4'd3;
  localparam logic [OpW-1:0] OpBanr = 4'd4;
  localparam logic [OpW-1:0] OpBani = 4'd5;
  localparam logic [OpW-1:0] OpBorr = 4'd6;
  localparam logic [OpW-1:0] OpBori = 4'd7;
  localparam logic [OpW-1:0] OpSetr = 4'd8;
  localparam logic [OpW-1:0] OpSeti = 4'd9;
  localparam logic [OpW-1:0] OpGtir = 4'd10;
  localparam logic [OpW-1:0] OpGtri = 4'd11;
  localparam logic [OpW-1:0] OpGtrr = 4'd12;
  localparam logic [OpW-1:0] OpEqir = 4'd13;
  localparam logic [OpW-1:0] OpEqri = 4'd14;
  localparam logic [OpW-1:0] OpEqrr = 4'd15;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [31:0]          a;
    logic [31:0]          b;
    logic [RegIdxW-1:0]   dst;
  } insn_t;

  typedef struct packed {
    logic [RegCount-1:0][DataWidth-1:0] value;
  } result_t;

endpackage

// ===== design/rme_queue.sv =====
// Two-entry queue used between the front and back ends and at the output.
// Depends on nothing; width is set by the instantiating module.
`timescale 1ns / 1ps

module rme_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_en,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop_en,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_en, pop_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/rme_front.sv =====
// Front end: holds the opcode map and translates each incoming request.
// Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rme_pkg::MapW-1:0]     cfg_wr_data,
  input  logic [rme_pkg::OpcodeW-1:0]  opcode,
  input  logic [31:0]                  operand_a,
  input  logic [31:0]                  operand_b,
  input  logic [1:0]                   dest_index,
  output rme_pkg::insn_t               item
);

  logic [rme_pkg::MapW-1:0] op_lut;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_lut <= rme_pkg::MapReset;
    end else if (cfg_wr_en) begin
      op_lut <= cfg_wr_data;
    end
  end

  always_comb begin
    item.op  = op_lut[opcode * rme_pkg::OpW +: rme_pkg::OpW];
    item.a   = operand_a;
    item.b   = operand_b;
    item.dst = dest_index[rme_pkg::RegIdxW-1:0];
  end

endmodule

// ===== design/rme_back.sv =====
// Back end: register file and ALU; one request per cycle unless res_full.
// Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_back (
  input  logic              clk,
  input  logic              rst,
  input  rme_pkg::insn_t    item,
  input  logic              item_valid,
  output logic              item_pop,
  input  logic              res_full,
  output logic              res_push,
  output rme_pkg::result_t  result
);

  localparam int DW = rme_pkg::DataWidth;

  logic [DW-1:0] regs      [rme_pkg::RegCount];
  logic [DW-1:0] regs_next [rme_pkg::RegCount];
  logic [DW-1:0] ra;
  logic [DW-1:0] rb;
  logic [DW-1:0] ia;
  logic [DW-1:0] ib;
  logic [DW-1:0] alu;
  logic          fire;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  assign ra = regs[item.a[rme_pkg::RegIdxW-1:0]];
  assign rb = regs[item.b[rme_pkg::RegIdxW-1:0]];
  assign ia = DW'(item.a);
  assign ib = DW'(item.b);

  always_comb begin
    case (item.op)
      rme_pkg::OpAddr: alu = ra + rb;
      rme_pkg::OpAddi: alu = ra + ib;
      rme_pkg::OpMulr: alu = ra * rb;
      rme_pkg::OpMuli: alu = ra * ib;
      rme_pkg::OpBanr: alu = ra & rb;
      rme_pkg::OpBani: alu = ra & ib;
      rme_pkg::OpBorr: alu = ra | rb;
      rme_pkg::OpBori: alu = ra | ib;
      rme_pkg::OpSetr: alu = ra;
      rme_pkg::OpSeti: alu = ia;
      rme_pkg::OpGtir: alu = DW'(ia > rb);
      rme_pkg::OpGtri: alu = DW'(ra > ib);
      rme_pkg::OpGtrr: alu = DW'(ra > rb);
      rme_pkg::OpEqir: alu = DW'(ia == rb);
      rme_pkg::OpEqri: alu = DW'(ra == ib);
      default:         alu = DW'(ra == rb);
    endcase
  end

  // Apply the write so the result carries the registers after the instruction
  always_comb begin
    for (int i = 0; i < rme_pkg::RegCount; i++) begin
      regs_next[i] = (item.dst == rme_pkg::RegIdxW'(i)) ? alu : regs[i];
      result.value[i] = regs_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rme_pkg::RegCount; i++) begin
        regs[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < rme_pkg::RegCount; i++) begin
        regs[i] <= regs_next[i];
      end
    end
  end

endmodule

// ===== design/register_machine_executor.sv =====
// Top level of the register machine executor.
// Depends on rme_pkg, rme_queue, rme_front and rme_back.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive opcode, operand_a, operand_b and dest_index with push;
//   a request is taken at a clock edge where push is high and full is low.
//   Result channel: while empty is low, reg0_value..reg3_value show the four
//   registers after the oldest unread instruction; pop high takes it.
//   Configuration: cfg_wr_en writes cfg_wr_data into the opcode map at the
//   edge; write only while no instruction is in flight.
// Timing
//   One instruction per cycle sustained while pop keeps the result queue from
//   filling. A taken request is decoded into a two-entry queue, executed by
//   the back end (ALU with 32x32 multipliers feeding the register file), and
//   pushed as a register snapshot into the result queue, whence it shows on
//   the result ports. The register file read-modify-write loop is the step
//   that sets the rate.
// Reset
//   rst (synchronous) clears both queues and all registers and reloads the
//   identity opcode map.
// Stalls
//   When pop stays low the result queue fills, the back end holds, the
//   request queue fills and full rises; nothing is dropped.

module register_machine_executor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [rme_pkg::OpcodeW-1:0]  opcode,
  input  logic [31:0]                  operand_a,
  input  logic [31:0]                  operand_b,
  input  logic [1:0]                   dest_index,
  input  logic                         pop,
  output logic                         empty,
  output logic [31:0]                  reg0_value,
  output logic [31:0]                  reg1_value,
  output logic [31:0]                  reg2_value,
  output logic [31:0]                  reg3_value,
  input  logic                         cfg_wr_en,
  input  logic [rme_pkg::MapW-1:0]     cfg_wr_data
);

  rme_pkg::insn_t   front_item;
  rme_pkg::insn_t   back_item;
  rme_pkg::result_t back_result;
  rme_pkg::result_t out_result;
  logic             insn_empty;
  logic             insn_pop;
  logic             res_full;
  logic             res_push;
  logic             in_take;
  logic             out_take;

  // Qualify the handshakes so the queues never see a push into full or a pop
  // from empty
  assign in_take  = push && !full;
  assign out_take = pop && !empty;

  rme_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (opcode),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .dest_index  (dest_index),
    .item        (front_item)
  );

  // Request queue: decouples decode from execution
  rme_queue #(
    .WIDTH ($bits(rme_pkg::insn_t))
  ) u_insn_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (in_take),
    .push_data (front_item),
    .full      (full),
    .pop_en    (insn_pop),
    .pop_data  (back_item),
    .empty     (insn_empty)
  );

  rme_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (!insn_empty),
    .item_pop   (insn_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .result     (back_result)
  );

  // Result queue: holds finished snapshots while the receiver stalls
  rme_queue #(
    .WIDTH ($bits(rme_pkg::result_t))
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (res_push),
    .push_data (back_result),
    .full      (res_full),
    .pop_en    (out_take),
    .pop_data  (out_result),
    .empty     (empty)
  );

  assign reg0_value = out_result.value[0];
  assign reg1_value = out_result.value[1];
  assign reg2_value = out_result.value[2];
  assign reg3_value = out_result.value[3];

endmodule
